// ===== rtl/irpfc_pkg.sv =====
// ----------------------------------------------------------------------------
// irpfc_pkg: shared types and constants for the ir pulse frame capture block
// ----------------------------------------------------------------------------
`default_nettype none
package irpfc_pkg;

  localparam int MaxPulses = 96;
  localparam int CntW = 7;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 20;

  localparam logic [CfgIdxW-1:0] REG_MIN_PULSE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_START_MIN   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_START_MAX   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FRAME_GAP   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FRAME_MAX   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MIN_FPULSES = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_ACTIVE_MS   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_REPEAT_MS   = 3'd7;

  localparam logic [1:0] END_NONE   = 2'd0;
  localparam logic [1:0] END_ACCEPT = 2'd1;
  localparam logic [1:0] END_NOISE  = 2'd2;

  localparam logic [1:0] CLS_IDLE   = 2'd0;
  localparam logic [1:0] CLS_FRAME  = 2'd1;
  localparam logic [1:0] CLS_REPEAT = 2'd2;
  localparam logic [1:0] CLS_NOISE  = 2'd3;

  // classified sample passed from front to back
  typedef struct packed {
    logic        is_edge;
    logic        prev_level;
    logic [31:0] dur;
    logic [31:0] now_us;
    logic [31:0] now_ms;
  } smp_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EDGE, ST_CLOSE, ST_WIN, ST_DIV, ST_EMIT
  } bst_t;

endpackage
`default_nettype wire

// ===== rtl/irpfc_front.sv =====
// ----------------------------------------------------------------------------
// irpfc_front: line level tracking and edge qualification
// ----------------------------------------------------------------------------
`default_nettype none
module irpfc_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic              in_line_in,
  input  wire logic [31:0]       in_now_us,
  input  wire logic [31:0]       in_now_ms,
  input  wire logic [15:0]       min_pulse,
  output irpfc_pkg::smp_t        q_data,
  output logic                   q_push,
  input  wire logic              q_full
);
  logic        level_r, level_nxt;
  logic [31:0] chg_r, chg_nxt;
  logic [31:0] dur;
  logic        change;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;
  assign change  = in_line_in != level_r;
  assign dur     = in_now_us - chg_r;

  always_comb begin
    q_data.is_edge    = change && (dur >= {16'd0, min_pulse});
    q_data.prev_level = level_r;
    q_data.dur        = dur;
    q_data.now_us     = in_now_us;
    q_data.now_ms     = in_now_ms;
    level_nxt = level_r;
    chg_nxt   = chg_r;
    if (q_push && change) begin
      level_nxt = in_line_in;
      chg_nxt   = in_now_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b1;
      chg_r   <= '0;
    end else begin
      level_r <= level_nxt;
      chg_r   <= chg_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/irpfc_fifo.sv =====
// ----------------------------------------------------------------------------
// irpfc_fifo: two-entry queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module irpfc_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire irpfc_pkg::smp_t wdata,
  output logic                 full,
  input  wire logic            pop,
  output irpfc_pkg::smp_t      rdata,
  output logic                 empty
);
  irpfc_pkg::smp_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/irpfc_back.sv =====
// ----------------------------------------------------------------------------
// irpfc_back: frame tracking, rate window, classification and result register
// ----------------------------------------------------------------------------
`default_nettype none
module irpfc_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire irpfc_pkg::smp_t s,
  input  wire logic            q_empty,
  output logic                 q_pop,
  input  wire logic [15:0]     start_min,
  input  wire logic [15:0]     start_max,
  input  wire logic [19:0]     frame_gap,
  input  wire logic [19:0]     frame_max,
  input  wire logic [6:0]      min_fpulses,
  input  wire logic [15:0]     active_ms,
  input  wire logic [13:0]     repeat_ms,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output logic                 out_captured,
  output logic [15:0]          out_pulse_us,
  output logic [1:0]           out_frame_end,
  output logic [1:0]           out_signal_class,
  output logic [6:0]           out_frame_pulses,
  output logic [22:0]          out_frame_total_us,
  output logic [15:0]          out_header_us,
  output logic                 out_frame_overflow,
  output logic [13:0]          out_frame_gap_ms,
  output logic [9:0]           out_edges_per_sec,
  output logic [6:0]           out_frames_per_sec,
  output logic [9:0]           out_noise_per_sec
);
  localparam int CW = irpfc_pkg::CntW;

  irpfc_pkg::bst_t st_r, st_nxt;

  logic        fopen_r, ovf_r;
  logic [CW-1:0] pcnt_r;
  logic [22:0] psum_r;
  logic [15:0] first_r;
  logic [31:0] fstart_r, ledge_r;
  logic [6:0]  dpul_r;
  logic [22:0] dsum_r;
  logic [15:0] dhdr_r;
  logic        dovf_r;
  logic [13:0] dgap_r;
  logic [31:0] lframe_r, lnoise_r;
  logic        fseen_r, nseen_r;
  logic [31:0] wstart_r, wedge_r, wfrm_r, wnoise_r;
  logic [9:0]  erate_r, nrate_r;
  logic [6:0]  frate_r;
  logic        cap_r;
  logic [15:0] stv_r;
  logic [1:0]  fend_r;
  logic [31:0] elapsed_r;
  // divider: one of three counts divided at a time, restoring, 1 bit/cycle
  logic [1:0]  dsel_r;
  logic [5:0]  dbit_r;
  logic [41:0] dnum_r;
  logic [31:0] drem_r;
  logic        oval_r;

  logic [15:0] sat16;
  logic        fits;
  logic [33:0] trial;
  logic [32:0] rem_sh;
  logic [41:0] prod;
  logic [31:0] dcount;
  logic [31:0] q_g, q_ms;

  assign q_pop     = st_r == irpfc_pkg::ST_EMIT && !oval_r;
  assign out_empty = !oval_r;
  assign sat16  = (s.dur > 32'd65535) ? 16'hFFFF : s.dur[15:0];
  assign fits   = pcnt_r < CW'(irpfc_pkg::MaxPulses);
  assign q_g    = s.now_ms - lframe_r;
  assign q_ms   = s.now_ms - wstart_r;
  // remainder stays below the divisor, so its shifted value needs 33 bits
  assign rem_sh = {drem_r, dnum_r[41]};
  assign trial  = {1'b0, rem_sh} - {2'b0, elapsed_r};

  always_comb begin
    case (dsel_r)
      2'd0:    dcount = wedge_r;
      2'd1:    dcount = wfrm_r;
      default: dcount = wnoise_r;
    endcase
    prod = {10'd0, dcount} * 42'd1000;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      irpfc_pkg::ST_IDLE:  if (!q_empty && !oval_r) st_nxt = irpfc_pkg::ST_EDGE;
      irpfc_pkg::ST_EDGE:  st_nxt = irpfc_pkg::ST_CLOSE;
      irpfc_pkg::ST_CLOSE: st_nxt = irpfc_pkg::ST_WIN;
      irpfc_pkg::ST_WIN:
        st_nxt = (q_ms >= 32'd1000) ? irpfc_pkg::ST_DIV : irpfc_pkg::ST_EMIT;
      irpfc_pkg::ST_DIV:
        if (dsel_r == 2'd2 && dbit_r == 6'd0) st_nxt = irpfc_pkg::ST_EMIT;
      irpfc_pkg::ST_EMIT:  st_nxt = irpfc_pkg::ST_IDLE;
      default:             st_nxt = irpfc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= irpfc_pkg::ST_IDLE;
      fopen_r <= 1'b0; ovf_r <= 1'b0; pcnt_r <= '0; psum_r <= '0; first_r <= '0;
      fstart_r <= '0; ledge_r <= '0;
      dpul_r <= '0; dsum_r <= '0; dhdr_r <= '0; dovf_r <= 1'b0; dgap_r <= '0;
      lframe_r <= '0; lnoise_r <= '0; fseen_r <= 1'b0; nseen_r <= 1'b0;
      wstart_r <= '0; wedge_r <= '0; wfrm_r <= '0; wnoise_r <= '0;
      erate_r <= '0; frate_r <= '0; nrate_r <= '0;
      oval_r <= 1'b0; dsel_r <= '0; dbit_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (oval_r && out_pop) oval_r <= 1'b0;
      case (st_r)
        irpfc_pkg::ST_EDGE: begin
          cap_r <= 1'b0; stv_r <= '0; fend_r <= irpfc_pkg::END_NONE;
          if (s.is_edge) begin
            if (wedge_r != '1) wedge_r <= wedge_r + 32'd1;
            ledge_r <= s.now_us;
            if ((!fopen_r && !s.prev_level && s.dur >= {16'd0, start_min} &&
                 s.dur <= {16'd0, start_max}) || fopen_r) begin
              if (!fopen_r) begin
                fstart_r <= s.now_us - s.dur;
                fopen_r  <= 1'b1;
                ovf_r    <= 1'b0;
              end
              if (fits || !fopen_r) begin
                if (!fopen_r || pcnt_r == '0) first_r <= sat16;
                pcnt_r <= fopen_r ? pcnt_r + CW'(1) : CW'(1);
                psum_r <= (fopen_r ? psum_r : 23'd0) + {7'd0, sat16};
                cap_r  <= 1'b1;
                stv_r  <= sat16;
              end else begin
                ovf_r <= 1'b1;
              end
            end else if (!s.prev_level) begin
              if (wnoise_r != '1) wnoise_r <= wnoise_r + 32'd1;
              lnoise_r <= s.now_ms; nseen_r <= 1'b1;
            end
          end
        end
        irpfc_pkg::ST_CLOSE: begin
          if (fopen_r && ((s.now_us - ledge_r) > {12'd0, frame_gap} ||
                          (s.now_us - fstart_r) > {12'd0, frame_max})) begin
            if (pcnt_r >= min_fpulses) begin
              if (wfrm_r != '1) wfrm_r <= wfrm_r + 32'd1;
              dgap_r <= !fseen_r ? 14'd0 :
                        (q_g > 32'd9999) ? 14'd9999 : q_g[13:0];
              lframe_r <= s.now_ms; fseen_r <= 1'b1;
              dpul_r <= pcnt_r; dsum_r <= psum_r; dhdr_r <= first_r;
              dovf_r <= ovf_r;
              fend_r <= irpfc_pkg::END_ACCEPT;
            end else begin
              if (wnoise_r != '1) wnoise_r <= wnoise_r + 32'd1;
              lnoise_r <= s.now_ms; nseen_r <= 1'b1;
              fend_r <= irpfc_pkg::END_NOISE;
            end
            fopen_r <= 1'b0; ovf_r <= 1'b0; pcnt_r <= '0; psum_r <= '0;
            first_r <= '0;
          end
        end
        irpfc_pkg::ST_WIN: begin
          elapsed_r <= q_ms;
          dsel_r <= 2'd0;
          dbit_r <= 6'd42;
        end
        irpfc_pkg::ST_DIV: begin
          if (dbit_r == 6'd42) begin
            dnum_r <= prod; drem_r <= '0; dbit_r <= 6'd41;
          end else begin
            // quotient bits shift into the low end of dnum_r
            if (!trial[33]) begin
              drem_r <= trial[31:0]; dnum_r <= {dnum_r[40:0], 1'b1};
            end else begin
              drem_r <= rem_sh[31:0]; dnum_r <= {dnum_r[40:0], 1'b0};
            end
            if (dbit_r == 6'd0) begin
              case (dsel_r)
                2'd0: erate_r <= (dnum_r[40:0] >= 41'd500 ||
                                  !trial[33] && dnum_r[40:0] >= 41'd499)
                                 ? 10'd999 : 10'({dnum_r[40:0], !trial[33]});
                2'd1: frate_r <= (dnum_r[40:0] >= 41'd50 ||
                                  !trial[33] && dnum_r[40:0] >= 41'd49)
                                 ? 7'd99 : 7'({dnum_r[40:0], !trial[33]});
                default: nrate_r <= (dnum_r[40:0] >= 41'd500 ||
                                     !trial[33] && dnum_r[40:0] >= 41'd499)
                                    ? 10'd999 : 10'({dnum_r[40:0], !trial[33]});
              endcase
              if (dsel_r == 2'd2) begin
                wedge_r <= '0; wfrm_r <= '0; wnoise_r <= '0; wstart_r <= s.now_ms;
              end else begin
                dsel_r <= dsel_r + 2'd1; dbit_r <= 6'd42;
              end
            end else begin
              dbit_r <= dbit_r - 6'd1;
            end
          end
        end
        irpfc_pkg::ST_EMIT: oval_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // classification from the registered state, evaluated in the emit cycle
  logic rf, rn, rep, noisy;
  always_comb begin
    rf    = fseen_r && ((s.now_ms - lframe_r) < {16'd0, active_ms});
    rn    = nseen_r && ((s.now_ms - lnoise_r) < {16'd0, active_ms});
    rep   = rf && ((dgap_r != '0 && dgap_r < repeat_ms) || frate_r >= 7'd2);
    noisy = rn && (frate_r == '0 || nrate_r > 10'd8);
  end

  logic [1:0] cls_r;
  always_ff @(posedge clk) begin
    if (st_r == irpfc_pkg::ST_EMIT) begin
      if (noisy && !rf)  cls_r <= irpfc_pkg::CLS_NOISE;
      else if (rep)      cls_r <= irpfc_pkg::CLS_REPEAT;
      else if (rf)       cls_r <= irpfc_pkg::CLS_FRAME;
      else if (noisy)    cls_r <= irpfc_pkg::CLS_NOISE;
      else               cls_r <= irpfc_pkg::CLS_IDLE;
    end
  end

  // result registers, loaded when the item finishes
  logic        ocap_r, oovf_r;
  logic [15:0] opul_r, ohdr_r;
  logic [1:0]  oend_r;
  logic [6:0]  ofp_r, ofr_r;
  logic [22:0] osum_r;
  logic [13:0] ogap_r;
  logic [9:0]  oer_r, onr_r;
  always_ff @(posedge clk) begin
    if (st_r == irpfc_pkg::ST_EMIT) begin
      ocap_r <= cap_r; opul_r <= stv_r; oend_r <= fend_r;
      ofp_r <= dpul_r; osum_r <= dsum_r; ohdr_r <= dhdr_r; oovf_r <= dovf_r;
      ogap_r <= dgap_r; oer_r <= erate_r; ofr_r <= frate_r; onr_r <= nrate_r;
    end
  end

  assign out_captured       = ocap_r;
  assign out_pulse_us       = opul_r;
  assign out_frame_end      = oend_r;
  assign out_signal_class   = cls_r;
  assign out_frame_pulses   = ofp_r;
  assign out_frame_total_us = osum_r;
  assign out_header_us      = ohdr_r;
  assign out_frame_overflow = oovf_r;
  assign out_frame_gap_ms   = ogap_r;
  assign out_edges_per_sec  = oer_r;
  assign out_frames_per_sec = ofr_r;
  assign out_noise_per_sec  = onr_r;
endmodule
`default_nettype wire

// ===== rtl/ir_pulse_frame_capture.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_frame_capture: infrared receiver pulse and frame analyzer
// Qualifies line edges, builds frames, keeps one-second rates and classifies.
// ----------------------------------------------------------------------------
// channel   ports                               transfer when
// input     in_push/in_full, in_line_in..ms     in_push && !in_full
// result    out_pop/out_empty, out_*            out_pop && !out_empty
// config    cfg_we, cfg_index, cfg_data         cfg_we
//
// a sample passes the back end states edge, close, win and emit in order; when
// the one-second window closes, a restoring divider runs for each of the three
// rates between win and emit for that sample
// reset is synchronous and active low
// the two-entry queue lets the front take samples while the back is busy
// ----------------------------------------------------------------------------
`default_nettype none
module ir_pulse_frame_capture (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic        in_line_in,
  input  wire logic [31:0] in_now_us,
  input  wire logic [31:0] in_now_ms,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic             out_captured,
  output logic [15:0]      out_pulse_us,
  output logic [1:0]       out_frame_end,
  output logic [1:0]       out_signal_class,
  output logic [6:0]       out_frame_pulses,
  output logic [22:0]      out_frame_total_us,
  output logic [15:0]      out_header_us,
  output logic             out_frame_overflow,
  output logic [13:0]      out_frame_gap_ms,
  output logic [9:0]       out_edges_per_sec,
  output logic [6:0]       out_frames_per_sec,
  output logic [9:0]       out_noise_per_sec,
  input  wire logic        cfg_we,
  input  wire logic [irpfc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [irpfc_pkg::CfgDataW-1:0] cfg_data
);
  // configuration registers
  logic [15:0] min_pulse_r, start_min_r, start_max_r, active_r;
  logic [19:0] gap_r, fmax_r;
  logic [6:0]  minfp_r;
  logic [13:0] repeat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pulse_r <= 16'd180; start_min_r <= 16'd1800; start_max_r <= 16'd20000;
      gap_r <= 20'd25000; fmax_r <= 20'd220000; minfp_r <= 7'd4;
      active_r <= 16'd650; repeat_r <= 14'd650;
    end else if (cfg_we) begin
      case (cfg_index)
        irpfc_pkg::REG_MIN_PULSE:   min_pulse_r <= cfg_data[15:0];
        irpfc_pkg::REG_START_MIN:   start_min_r <= cfg_data[15:0];
        irpfc_pkg::REG_START_MAX:   start_max_r <= cfg_data[15:0];
        irpfc_pkg::REG_FRAME_GAP:   gap_r       <= cfg_data;
        irpfc_pkg::REG_FRAME_MAX:   fmax_r      <= cfg_data;
        irpfc_pkg::REG_MIN_FPULSES: minfp_r     <= cfg_data[6:0];
        irpfc_pkg::REG_ACTIVE_MS:   active_r    <= cfg_data[15:0];
        irpfc_pkg::REG_REPEAT_MS:   repeat_r    <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  irpfc_pkg::smp_t q_wdata, q_rdata;
  logic q_push, q_full, q_pop, q_empty;

  irpfc_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_line_in, .in_now_us, .in_now_ms,
    .min_pulse(min_pulse_r), .q_data(q_wdata), .q_push, .q_full
  );

  irpfc_fifo u_fifo (
    .clk, .rst_n, .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  irpfc_back u_back (
    .clk, .rst_n, .s(q_rdata), .q_empty, .q_pop,
    .start_min(start_min_r), .start_max(start_max_r), .frame_gap(gap_r),
    .frame_max(fmax_r), .min_fpulses(minfp_r), .active_ms(active_r),
    .repeat_ms(repeat_r), .out_empty, .out_pop, .out_captured, .out_pulse_us,
    .out_frame_end, .out_signal_class, .out_frame_pulses, .out_frame_total_us,
    .out_header_us, .out_frame_overflow, .out_frame_gap_ms, .out_edges_per_sec,
    .out_frames_per_sec, .out_noise_per_sec
  );
endmodule
`default_nettype wire

// ===== tb/ir_pulse_frame_capture_tb.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_frame_capture_tb: self-checking bench for the ir frame analyzer
// Drives receiver sample streams (real frames, glitches, noise, timestamp
// wraps) under several register settings and checks each result transfer
// against a cycle-free predictor of the frame, rate and class logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ir_pulse_frame_capture_tb;

  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 200;   // covers the rate division
  localparam int HoldCycles = 3000;

  // one result transfer, field order matches the output ports
  typedef struct packed {
    bit        captured;
    bit [15:0] pulse_us;
    bit [1:0]  frame_end;
    bit [1:0]  signal_class;
    bit [6:0]  frame_pulses;
    bit [22:0] frame_total_us;
    bit [15:0] header_us;
    bit        frame_overflow;
    bit [13:0] frame_gap_ms;
    bit [9:0]  edges_per_sec;
    bit [6:0]  frames_per_sec;
    bit [9:0]  noise_per_sec;
  } ir_result_t;

  // predicts the analyzer and holds the results still owed by it
  class frame_scoreboard;
    bit [31:0] min_pulse, start_min, start_max, frame_gap, frame_max;
    bit [31:0] min_fpulses, active_ms, repeat_ms;
    bit        level, fopen, open_ovf, done_ovf, frame_seen, noise_seen;
    bit [31:0] last_change, last_edge, fstart;
    bit [31:0] pcount, psum, first_len;
    bit [31:0] done_pulses, done_sum, done_header, done_gap;
    bit [31:0] last_frame_ms, last_noise_ms;
    bit [31:0] win_start, win_edges, win_frames, win_noise;
    bit [31:0] edge_rate, frame_rate, noise_rate;
    ir_result_t owed[$];
    int mismatches;

    function new();
      min_pulse = 180; start_min = 1800; start_max = 20000;
      frame_gap = 25000; frame_max = 220000; min_fpulses = 4;
      active_ms = 650; repeat_ms = 650;
      level = 1;
    endfunction

    function void set_reg(bit [2:0] idx, bit [19:0] data);
      case (idx)
        irpfc_pkg::REG_MIN_PULSE:   min_pulse = data[15:0];
        irpfc_pkg::REG_START_MIN:   start_min = data[15:0];
        irpfc_pkg::REG_START_MAX:   start_max = data[15:0];
        irpfc_pkg::REG_FRAME_GAP:   frame_gap = data;
        irpfc_pkg::REG_FRAME_MAX:   frame_max = data;
        irpfc_pkg::REG_MIN_FPULSES: min_fpulses = data[6:0];
        irpfc_pkg::REG_ACTIVE_MS:   active_ms = data[15:0];
        irpfc_pkg::REG_REPEAT_MS:   repeat_ms = data[13:0];
        default: ;
      endcase
    endfunction

    function bit [31:0] sat_inc(bit [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    function bit [31:0] rate_of(bit [31:0] cnt, bit [31:0] elapsed, bit [31:0] cap);
      longint unsigned r;
      r = (64'(cnt) * 1000) / 64'(elapsed);
      return (r > cap) ? cap : r[31:0];
    endfunction

    function void add_pulse(bit [31:0] dur, output bit cap, output bit [15:0] len);
      cap = 0;
      len = 0;
      if (pcount < irpfc_pkg::MaxPulses) begin
        len = (dur > 65535) ? 16'hFFFF : dur[15:0];
        if (pcount == 0) first_len = len;
        pcount++;
        psum = (psum + len) & 32'h7F_FFFF;
        cap = 1;
      end else begin
        open_ovf = 1;
      end
    endfunction

    function void mark_noise(bit [31:0] ms);
      win_noise = sat_inc(win_noise);
      last_noise_ms = ms;
      noise_seen = 1;
    endfunction

    function bit [1:0] close_frame(bit [31:0] ms);
      bit [1:0] res;
      bit [31:0] g;
      if (pcount >= min_fpulses) begin
        win_frames = sat_inc(win_frames);
        g = ms - last_frame_ms;
        done_gap = !frame_seen ? 0 : (g > 9999) ? 9999 : g;
        last_frame_ms = ms;
        frame_seen = 1;
        done_pulses = pcount;
        done_sum = psum;
        done_header = first_len;
        done_ovf = open_ovf;
        res = irpfc_pkg::END_ACCEPT;
      end else begin
        mark_noise(ms);
        res = irpfc_pkg::END_NOISE;
      end
      fopen = 0; open_ovf = 0; pcount = 0; psum = 0; first_len = 0;
      return res;
    endfunction

    function bit [1:0] classify(bit [31:0] ms);
      bit rf, rn, rep, noisy;
      rf = frame_seen && ((ms - last_frame_ms) < active_ms);
      rn = noise_seen && ((ms - last_noise_ms) < active_ms);
      rep = rf && ((done_gap > 0 && done_gap < repeat_ms) || frame_rate >= 2);
      noisy = rn && (frame_rate == 0 || noise_rate > 8);
      if (noisy && !rf) return irpfc_pkg::CLS_NOISE;
      if (rep) return irpfc_pkg::CLS_REPEAT;
      if (rf) return irpfc_pkg::CLS_FRAME;
      if (noisy) return irpfc_pkg::CLS_NOISE;
      return irpfc_pkg::CLS_IDLE;
    endfunction

    // accepted input transfer: advance the state and queue the result
    function void note_sample(bit line, bit [31:0] us, bit [31:0] ms);
      ir_result_t r;
      bit [31:0] dur, elapsed;
      bit prev, cap;
      bit [15:0] len;
      r = '0;
      cap = 0;
      len = 0;
      if (line != level) begin
        dur = us - last_change;
        prev = level;
        if (dur >= min_pulse) begin
          win_edges = sat_inc(win_edges);
          last_edge = us;
          if (!fopen && prev == 0 && dur >= start_min && dur <= start_max) begin
            fopen = 1;
            fstart = us - dur;
            pcount = 0; psum = 0; open_ovf = 0;
            add_pulse(dur, cap, len);
          end else if (fopen) begin
            add_pulse(dur, cap, len);
          end else if (prev == 0) begin
            mark_noise(ms);
          end
        end
        level = line;
        last_change = us;
      end
      r.frame_end = irpfc_pkg::END_NONE;
      if (fopen && ((us - last_edge) > frame_gap || (us - fstart) > frame_max))
        r.frame_end = close_frame(ms);
      elapsed = ms - win_start;
      if (elapsed >= 1000) begin
        edge_rate = rate_of(win_edges, elapsed, 999);
        frame_rate = rate_of(win_frames, elapsed, 99);
        noise_rate = rate_of(win_noise, elapsed, 999);
        win_edges = 0; win_frames = 0; win_noise = 0;
        win_start = ms;
      end
      r.captured = cap;
      r.pulse_us = cap ? len : 16'd0;
      r.signal_class = classify(ms);
      r.frame_pulses = done_pulses[6:0];
      r.frame_total_us = done_sum[22:0];
      r.header_us = done_header[15:0];
      r.frame_overflow = done_ovf;
      r.frame_gap_ms = done_gap[13:0];
      r.edges_per_sec = edge_rate[9:0];
      r.frames_per_sec = frame_rate[6:0];
      r.noise_per_sec = noise_rate[9:0];
      owed.push_back(r);
    endfunction

    function string show(ir_result_t r);
      return $sformatf({"cap=%0d pulse=%0d end=%0d cls=%0d fp=%0d tot=%0d hdr=%0d ",
                        "ovf=%0d gap=%0d eps=%0d fps=%0d nps=%0d"},
                       r.captured, r.pulse_us, r.frame_end, r.signal_class,
                       r.frame_pulses, r.frame_total_us, r.header_us,
                       r.frame_overflow, r.frame_gap_ms, r.edges_per_sec,
                       r.frames_per_sec, r.noise_per_sec);
    endfunction

    function void check_result(ir_result_t act);
      ir_result_t exp;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %s", show(act));
        return;
      end
      exp = owed.pop_front();
      if (exp != act) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch at %0t", $realtime);
          $display("  expected %s", show(exp));
          $display("  actual   %s", show(act));
        end
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_push, in_full, in_line_in;
  logic [31:0] in_now_us, in_now_ms;
  logic        out_empty, out_pop;
  logic        out_captured, out_frame_overflow;
  logic [15:0] out_pulse_us, out_header_us;
  logic [1:0]  out_frame_end, out_signal_class;
  logic [6:0]  out_frame_pulses, out_frames_per_sec;
  logic [22:0] out_frame_total_us;
  logic [13:0] out_frame_gap_ms;
  logic [9:0]  out_edges_per_sec, out_noise_per_sec;
  logic        cfg_we;
  logic [irpfc_pkg::CfgIdxW-1:0]  cfg_index;
  logic [irpfc_pkg::CfgDataW-1:0] cfg_data;

  ir_pulse_frame_capture DUT (.*);

  frame_scoreboard sb = new();

  // stimulus-side view of the receiver line
  bit [31:0] t_us, t_ms, ms_frac;
  bit        lvl = 1;
  bit        freeze_ms;       // ms stalls so many frames land in one window
  bit        no_idle;         // both sides transfer back to back
  bit        hold_req;        // asks the receiver for a long hold-off
  int        n_sent;
  int        cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // one sample transfer; entered and left at a falling edge
  task automatic send_sample(bit line, bit [31:0] us, bit [31:0] ms);
    while (!no_idle && $urandom_range(99) < 31) begin
      in_push <= 0;
      @(negedge clk);
    end
    in_push <= 1;
    in_line_in <= line;
    in_now_us <= us;
    in_now_ms <= ms;
    do @(posedge clk); while (in_full);
    sb.note_sample(line, us, ms);
    n_sent++;
    @(negedge clk);
  endtask

  // move the clock of the line forward, ms tracking us unless frozen
  task automatic advance(bit [31:0] dus);
    t_us += dus;
    if (!freeze_ms) begin
      ms_frac += dus;
      t_ms += ms_frac / 1000;
      ms_frac = ms_frac % 1000;
    end
    // occasional jump that closes the rate window
    if ($urandom_range(999) < (freeze_ms ? 5 : 30)) t_ms += $urandom_range(1500, 1000);
  endtask

  task automatic toggle(bit [31:0] dus);
    advance(dus);
    lvl = ~lvl;
    send_sample(lvl, t_us, t_ms);
  endtask

  task automatic hold_line(bit [31:0] dus);
    advance(dus);
    send_sample(lvl, t_us, t_ms);
  endtask

  // mark or space length: mostly real, some glitches, some beyond 16 bits
  function automatic bit [31:0] pulse_len();
    int r;
    r = $urandom_range(99);
    if (r < 5) return (sb.min_pulse > 0) ? $urandom_range(sb.min_pulse - 1, 0) : 0;
    if (r < 8) return 65536 + $urandom_range(20000);
    if (r < 40) return sb.min_pulse + 560;
    if (r < 70) return sb.min_pulse + 1690;
    return sb.min_pulse + $urandom_range(3000);
  endfunction

  // header low pulse, data pulses, then silence until the frame closes
  task automatic send_frame(int n);
    bit [31:0] hdr;
    while (lvl != 0) toggle(pulse_len());
    if (sb.start_min <= sb.start_max && $urandom_range(9) != 0)
      hdr = sb.start_min + $urandom_range(sb.start_max - sb.start_min);
    else
      hdr = $urandom_range(65535);
    toggle(hdr);
    repeat (n - 1) toggle(pulse_len());
    hold_line(sb.frame_gap + 1 + $urandom_range(2000));
  endtask

  // short bursts and samples with every timestamp bit random
  task automatic send_noise();
    repeat ($urandom_range(6, 1)) begin
      if ($urandom_range(3) == 0) begin
        lvl = $urandom_range(1);
        t_us = $urandom;
        t_ms = $urandom;
        send_sample(lvl, t_us, t_ms);
      end else begin
        toggle($urandom_range(3000));
      end
    end
  endtask

  task automatic cfg_write(bit [2:0] idx, bit [19:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic apply_cfg(bit [19:0] mp, bit [19:0] smin, bit [19:0] smax, bit [19:0] gap,
                           bit [19:0] fmax, bit [19:0] mfp, bit [19:0] act, bit [19:0] rep);
    cfg_write(irpfc_pkg::REG_MIN_PULSE, mp);
    cfg_write(irpfc_pkg::REG_START_MIN, smin);
    cfg_write(irpfc_pkg::REG_START_MAX, smax);
    cfg_write(irpfc_pkg::REG_FRAME_GAP, gap);
    cfg_write(irpfc_pkg::REG_FRAME_MAX, fmax);
    cfg_write(irpfc_pkg::REG_MIN_FPULSES, mfp);
    cfg_write(irpfc_pkg::REG_ACTIVE_MS, act);
    cfg_write(irpfc_pkg::REG_REPEAT_MS, rep);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  // wait until every owed result has been popped, then let the back end settle
  task automatic drain();
    in_push <= 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic run_random(int count);
    int stop_at;
    stop_at = n_sent + count;
    while (n_sent < stop_at) begin
      if ($urandom_range(99) < 70)
        send_frame(($urandom_range(19) == 0) ? $urandom_range(110, 97)
                                             : $urandom_range(40, 1));
      else
        send_noise();
    end
  endtask

  initial begin
    rst_n = 0;
    in_push = 0; in_line_in = 1; in_now_us = 0; in_now_ms = 0;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: frame at ms zero, glitch, saturated pulse, noise header,
    // repeat frame, short frame as noise, us and ms wraps
    send_sample(1'b1, 0, 0);
    send_sample(1'b0, 100, 0);
    send_sample(1'b1, 9100, 0);
    send_sample(1'b0, 9660, 0);
    send_sample(1'b1, 10220, 0);
    send_sample(1'b0, 10780, 0);
    send_sample(1'b1, 12470, 0);
    send_sample(1'b0, 82470, 0);
    send_sample(1'b0, 110000, 0);
    send_sample(1'b1, 110500, 300);
    send_sample(1'b0, 111000, 300);
    send_sample(1'b1, 120000, 310);
    send_sample(1'b0, 120560, 310);
    send_sample(1'b1, 121120, 310);
    send_sample(1'b0, 121680, 310);
    send_sample(1'b1, 122240, 311);
    send_sample(1'b1, 150000, 340);
    send_sample(1'b0, 32'hFFFF_FF00, 1200);
    send_sample(1'b1, 32'h0000_2000, 1201);
    send_sample(1'b0, 32'h0000_2300, 1202);
    send_sample(1'b1, 32'h0000_2400, 1203);
    send_sample(1'b1, 32'h0001_0000, 32'hFFFF_FFFF);
    send_sample(1'b0, 32'hFFFF_FFFF, 32'h0000_0005);
    lvl = 0; t_us = 32'hFFFF_FFFF; t_ms = 5;
    run_random(200);

    // low extremes, ms frozen so frames pile up in one window
    drain();
    apply_cfg(20'd0, 20'd0, 20'hFFFF, 20'd0, 20'd0, 20'd1, 20'd0, 20'd0);
    freeze_ms = 1;
    run_random(230);
    freeze_ms = 0;

    // high extremes
    drain();
    apply_cfg(20'hFFFF, 20'hFFFF, 20'hFFFF, 20'hFFFFF, 20'hFFFFF, 20'd96, 20'hFFFF,
              20'd9999);
    run_random(200);

    // random settings with stray bits above each register narrower than cfg_data
    drain();
    apply_cfg({4'($urandom_range(15)), 16'($urandom_range(400))},
              {4'($urandom_range(15)), 16'($urandom_range(3000, 500))},
              {4'($urandom_range(15)), 16'($urandom_range(30000, 3000))},
              20'($urandom_range(60000, 2000)), 20'($urandom_range(400000, 50000)),
              {13'($urandom_range(8191)), 7'($urandom_range(96, 1))},
              {4'($urandom_range(15)), 16'($urandom_range(2000))},
              {6'($urandom_range(63)), 14'($urandom_range(9999))});
    hold_req = 1;     // receiver stalls while samples keep coming
    run_random(230);

    // typical settings, first part back to back
    drain();
    apply_cfg(20'd180, 20'd1800, 20'd20000, 20'd25000, 20'd220000, 20'd4, 20'd650,
              20'd650);
    no_idle = 1;
    run_random(120);
    no_idle = 0;
    run_random(120);

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  initial begin
    int hold_left;
    hold_left = 0;
    out_pop = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 0;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left = HoldCycles;
        out_pop <= 0;
      end else begin
        out_pop <= no_idle || ($urandom_range(99) >= 31);
      end
    end
  end

  always @(posedge clk) begin
    ir_result_t act;
    if (rst_n && out_pop && !out_empty) begin
      act = {out_captured, out_pulse_us, out_frame_end, out_signal_class,
             out_frame_pulses, out_frame_total_us, out_header_us,
             out_frame_overflow, out_frame_gap_ms, out_edges_per_sec,
             out_frames_per_sec, out_noise_per_sec};
      sb.check_result(act);
    end
  end

endmodule
